@@ rtl/ptu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_pkg: shared types and constants for the pheromone table update core
// Table geometry, arithmetic widths, item structs, codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptu_pkg;

  // Table geometry
  localparam int NUM_ARCS = 1024;
  localparam int ARC_W    = $clog2(NUM_ARCS);

  // Arithmetic widths
  localparam int TRAIL_W   = 32;
  localparam int RATE_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = TRAIL_W + RATE_W;        // v * rate
  localparam int NUM_W     = TRAIL_W + FRAC_W;        // tau << 16
  localparam int LEN_W     = 16;
  localparam int PASS_W    = 8;
  localparam int LSQ_W     = 2 * LEN_W;               // len * len
  localparam int LSQR_W    = LSQ_W + RATE_W;          // len * len * rho
  localparam int DEN_W     = LSQR_W + PASS_W;         // full divisor
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR_LEVEL      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EVAP_RATE        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_EVAP_RATE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPOSIT_CONSTANT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_USE_EXIT_TABLE   = 3'd4;

  // Register reset values
  localparam logic [TRAIL_W-1:0] FLOOR_RST = 32'd0;
  localparam logic [RATE_W-1:0]  RATE_RST  = 16'd32768;
  localparam logic [TRAIL_W-1:0] TAU_RST   = 32'd65536;

  // Item kinds
  localparam logic [1:0] KIND_INIT    = 2'd0;
  localparam logic [1:0] KIND_EVAP    = 2'd1;
  localparam logic [1:0] KIND_DEPOSIT = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_ZERO_LEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SW_CLEAR = 2'd0,
    SW_FILL  = 2'd1,
    SW_EVAP  = 2'd2
  } sweep_mode_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic              table_select;
    logic [9:0]        arc_index;
    logic [PASS_W-1:0] pass_count;
    logic [LEN_W-1:0]  path_length;
    logic              valid_ant;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TRAIL_W-1:0] trail_value;
  } out_item_t;

  typedef struct packed {
    logic        start_sweep;
    sweep_mode_e sweep_mode;
    logic        load_item;
    logic        mul1;
    logic        mul2;
    logic        mul3;
    logic        div_step;
    logic        dep_write;
    logic        res_set;
    status_e     res_code;
    logic        out_load;
  } ptu_cmd_t;

  typedef struct packed {
    logic is_init;
    logic is_evap;
    logic dep_go;
    logic dep_zero;
    logic sweep_idle;
    logic div_last;
  } ptu_status_t;

endpackage

@@ rtl/pheromone_table_update_core.sv @@
`timescale 1ns / 1ps
// Deposit runs 3 multiply steps, 48 divider steps, an add-write and an
//   output load; init and evaporate each run a full table sweep. One item
//   in flight; the next is taken once its result has entered the output
//   register.
// Reset: asynchronous; then a clearing pass zeroes both tables,
//   in_stall_o stays high, config writes are still taken.
// ----------------------------------------------------------------------------
// pheromone_table_update_core: Ant System pheromone table engine
// Two Q16.16 trail tables (main, exit) with init, evaporate and deposit items.
// ----------------------------------------------------------------------------
module pheromone_table_update_core import ptu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input item channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  // result item channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Controller decides what happens each cycle; the datapath owns the two
  // trail RAMs, the sweep pipeline and the deposit divider.
  ptu_cmd_t    cmd;
  ptu_status_t status;

  // Sequencer. An item is taken only in idle; the output register frees the
  // block to take the next item while a result still waits downstream.
  ptu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath. Evaporate reads both tables side by side: read, subtract v*rho
  // (or clamp to the floor when below it), write back; the exit table is written
  // only when enabled. Deposit divides tau<<16 by rho*L*L*passes one quotient
  // bit per cycle; a zero divisor yields an all-ones quotient, which saturates the trail.
  ptu_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/ptu_trail_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_trail_ram: one trail table
// NUM_ARCS x 32 storage, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ptu_trail_ram import ptu_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ARC_W-1:0]   waddr_i,
  input  logic [TRAIL_W-1:0] wdata_i,
  input  logic [ARC_W-1:0]   raddr_i,
  output logic [TRAIL_W-1:0] rdata_o
);

  logic [TRAIL_W-1:0] mem_q [NUM_ARCS];
  logic [TRAIL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_datapath: tables, config registers, sweep pipeline and deposit math
// Sweep engine (clear/fill/evaporate), divisor multipliers, restoring
// divider, saturating deposit add, result and output registers.
// ----------------------------------------------------------------------------
module ptu_datapath import ptu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  in_item_t               in_item_i,
  input  ptu_cmd_t               cmd_i,
  output ptu_status_t            status_o,
  output out_item_t              out_item_o
);

  // Config registers
  logic [TRAIL_W-1:0] floor_q;
  logic [RATE_W-1:0]  rate_q;
  logic [RATE_W-1:0]  exit_rate_q;
  logic [TRAIL_W-1:0] tau_q;
  logic               use_exit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q     <= FLOOR_RST;
      rate_q      <= RATE_RST;
      exit_rate_q <= RATE_RST;
      tau_q       <= TAU_RST;
      use_exit_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FLOOR_LEVEL:      floor_q     <= cfg_data_i[TRAIL_W-1:0];
        CFG_EVAP_RATE:        rate_q      <= cfg_data_i[RATE_W-1:0];
        CFG_EXIT_EVAP_RATE:   exit_rate_q <= cfg_data_i[RATE_W-1:0];
        CFG_DEPOSIT_CONSTANT: tau_q       <= cfg_data_i[TRAIL_W-1:0];
        CFG_USE_EXIT_TABLE:   use_exit_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Item classification
  logic target_ok;
  logic arc_ok;
  logic dep_ok;

  always_comb begin
    target_ok = !in_item_i.table_select || use_exit_q;
    arc_ok    = (32'(in_item_i.arc_index) < 32'(NUM_ARCS));
    dep_ok    = (in_item_i.kind == KIND_DEPOSIT) && in_item_i.valid_ant &&
                (in_item_i.pass_count != '0) && target_ok && arc_ok;
  end

  // Captured item
  logic               sel_q;
  logic [ARC_W-1:0]   arc_q;
  logic [PASS_W-1:0]  passes_q;
  logic [LEN_W-1:0]   len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sel_q    <= in_item_i.table_select;
      arc_q    <= ARC_W'(in_item_i.arc_index);
      passes_q <= in_item_i.pass_count;
      len_q    <= in_item_i.path_length;
    end
  end

  // Sweep address generator
  logic             issue_q;
  logic [ARC_W-1:0] addr_q;
  sweep_mode_e      mode_q;
  logic             v1_q, v2_q;
  logic             addr_last;

  assign addr_last = (addr_q == ARC_W'(NUM_ARCS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      addr_q  <= '0;
      mode_q  <= SW_CLEAR;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      if (cmd_i.start_sweep) begin
        issue_q <= 1'b1;
        addr_q  <= '0;
        mode_q  <= cmd_i.sweep_mode;
      end else if (issue_q) begin
        issue_q <= !addr_last;
        addr_q  <= addr_last ? '0 : addr_q + ARC_W'(1);
      end
      v1_q <= issue_q && (mode_q == SW_EVAP);
      v2_q <= v1_q;
    end
  end

  // Tables
  logic               we_m, we_e;
  logic [ARC_W-1:0]   waddr;
  logic [TRAIL_W-1:0] wdata_m, wdata_e;
  logic [ARC_W-1:0]   raddr;
  logic [TRAIL_W-1:0] rd_m, rd_e;

  assign raddr = issue_q ? addr_q : arc_q;

  ptu_trail_ram u_main_ram (
    .clk_i   (clk_i),
    .we_i    (we_m),
    .waddr_i (waddr),
    .wdata_i (wdata_m),
    .raddr_i (raddr),
    .rdata_o (rd_m)
  );

  ptu_trail_ram u_exit_ram (
    .clk_i   (clk_i),
    .we_i    (we_e),
    .waddr_i (waddr),
    .wdata_i (wdata_e),
    .raddr_i (raddr),
    .rdata_o (rd_e)
  );

  // Evaporate pipeline: read, multiply, write back
  logic [ARC_W-1:0]   a1_q, a2_q;
  logic [TRAIL_W-1:0] vm_q, ve_q;
  logic [PROD_W-1:0]  pm_q, pe_q;
  logic               bm_q, be_q;
  logic [TRAIL_W-1:0] evap_m, evap_e;

  always_ff @(posedge clk_i) begin
    a1_q <= addr_q;
    a2_q <= a1_q;
    vm_q <= rd_m;
    ve_q <= rd_e;
    pm_q <= PROD_W'(rd_m) * PROD_W'(rate_q);
    pe_q <= PROD_W'(rd_e) * PROD_W'(exit_rate_q);
    bm_q <= (rd_m < floor_q);
    be_q <= (rd_e < floor_q);
  end

  assign evap_m = bm_q ? floor_q : vm_q - pm_q[PROD_W-1:FRAC_W];
  assign evap_e = be_q ? floor_q : ve_q - pe_q[PROD_W-1:FRAC_W];

  // Divisor products and restoring divider
  logic [LSQ_W-1:0]     p1_q;
  logic [LSQR_W-1:0]    p2_q;
  logic [DEN_W-1:0]     den_q;
  logic [NUM_W-1:0]     quo_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     rem_d;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_diff;
  logic                 qbit;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  always_comb begin
    rem_sh   = {rem_q, quo_q[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_q};
    qbit     = (rem_sh >= {1'b0, den_q});
    rem_d    = qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1_q <= LSQ_W'(len_q) * LSQ_W'(len_q);
    end
    if (cmd_i.mul2) begin
      p2_q <= LSQR_W'(p1_q) * LSQR_W'(rate_q);
    end
    if (cmd_i.mul3) begin
      den_q <= DEN_W'(p2_q) * DEN_W'(passes_q);
      quo_q <= {tau_q, {FRAC_W{1'b0}}};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.mul3) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  // Saturating deposit add
  logic [TRAIL_W-1:0] add_amt;
  logic [TRAIL_W-1:0] dep_old;
  logic [TRAIL_W:0]   sum;
  logic [TRAIL_W-1:0] sum_sat;

  always_comb begin
    add_amt = (|quo_q[NUM_W-1:TRAIL_W]) ? '1 : quo_q[TRAIL_W-1:0];
    dep_old = sel_q ? rd_e : rd_m;
    sum     = {1'b0, dep_old} + {1'b0, add_amt};
    sum_sat = sum[TRAIL_W] ? '1 : sum[TRAIL_W-1:0];
  end

  // Write port steering
  always_comb begin
    we_m    = 1'b0;
    we_e    = 1'b0;
    waddr   = addr_q;
    wdata_m = '0;
    wdata_e = '0;
    if (issue_q && (mode_q != SW_EVAP)) begin
      we_m    = 1'b1;
      we_e    = 1'b1;
      wdata_m = (mode_q == SW_FILL) ? tau_q : '0;
      wdata_e = (mode_q == SW_FILL) ? tau_q : '0;
    end else if (v2_q) begin
      we_m    = 1'b1;
      we_e    = use_exit_q;
      waddr   = a2_q;
      wdata_m = evap_m;
      wdata_e = evap_e;
    end else if (cmd_i.dep_write) begin
      we_m    = !sel_q;
      we_e    = sel_q;
      waddr   = arc_q;
      wdata_m = sum_sat;
      wdata_e = sum_sat;
    end
  end

  // Result hold and output registers
  out_item_t res_q;
  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_q.status      <= cmd_i.res_code;
      res_q.trail_value <= '0;
    end else if (cmd_i.dep_write) begin
      res_q.status      <= ST_DONE;
      res_q.trail_value <= sum_sat;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_item_o = out_q;

  always_comb begin
    status_o.is_init    = (in_item_i.kind == KIND_INIT);
    status_o.is_evap    = (in_item_i.kind == KIND_EVAP);
    status_o.dep_go     = dep_ok && (in_item_i.path_length != '0);
    status_o.dep_zero   = dep_ok && (in_item_i.path_length == '0);
    status_o.sweep_idle = !issue_q && !v1_q && !v2_q;
    status_o.div_last   = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  end

endmodule

@@ rtl/ptu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_ctrl: sequencing state machine
// Runs the post-reset clear, dispatches items, steps the deposit math and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module ptu_ctrl import ptu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  ptu_status_t status_i,
  output ptu_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_CLR_GO  = 9'b000000001,
    S_CLR_RUN = 9'b000000010,
    S_IDLE    = 9'b000000100,
    S_SWEEP   = 9'b000001000,
    S_MUL1    = 9'b000010000,
    S_MUL2    = 9'b000100000,
    S_MUL3    = 9'b001000000,
    S_DIV     = 9'b010000000,
    S_ADD     = 9'b100000000
  } state_e;

  // separate flag for the wait-for-output step keeps the FSM small
  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || done_q;

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    cmd_o   = '0;
    if (done_q) begin
      // result parked in the hold register, push it to the output stage
      if (out_free) begin
        cmd_o.out_load = 1'b1;
        done_d         = 1'b0;
      end
    end else begin
      case (state_q)
        S_CLR_GO: begin
          cmd_o.start_sweep = 1'b1;
          cmd_o.sweep_mode  = SW_CLEAR;
          state_d           = S_CLR_RUN;
        end
        S_CLR_RUN: begin
          if (status_i.sweep_idle) begin
            state_d = S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.load_item = 1'b1;
            cmd_o.res_set   = 1'b1;
            cmd_o.res_code  = ST_IGNORED;
            if (status_i.is_init) begin
              cmd_o.res_code    = ST_DONE;
              cmd_o.start_sweep = 1'b1;
              cmd_o.sweep_mode  = SW_FILL;
              state_d           = S_SWEEP;
            end else if (status_i.is_evap) begin
              cmd_o.res_code    = ST_DONE;
              cmd_o.start_sweep = 1'b1;
              cmd_o.sweep_mode  = SW_EVAP;
              state_d           = S_SWEEP;
            end else if (status_i.dep_go) begin
              cmd_o.res_set = 1'b0;
              state_d       = S_MUL1;
            end else if (status_i.dep_zero) begin
              cmd_o.res_code = ST_ZERO_LEN;
              done_d         = 1'b1;
            end else begin
              done_d = 1'b1;
            end
          end
        end
        S_SWEEP: begin
          if (status_i.sweep_idle) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        end
        S_MUL1: begin
          cmd_o.mul1 = 1'b1;
          state_d    = S_MUL2;
        end
        S_MUL2: begin
          cmd_o.mul2 = 1'b1;
          state_d    = S_MUL3;
        end
        S_MUL3: begin
          cmd_o.mul3 = 1'b1;
          state_d    = S_DIV;
        end
        S_DIV: begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_last) begin
            state_d = S_ADD;
          end
        end
        S_ADD: begin
          cmd_o.dep_write = 1'b1;
          state_d         = S_IDLE;
          done_d          = 1'b1;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR_GO;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/ptu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptu_checker: port-level checks for the pheromone table update core
// Watches the item channels; bound onto the top level.
// ----------------------------------------------------------------------------
module ptu_checker import ptu_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // a new result only comes out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == ST_DONE) ||
                    (out_item_o.status == ST_IGNORED) ||
                    (out_item_o.status == ST_ZERO_LEN))
    else $error("bad status code");

  // only a done item carries a trail value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_DONE) |-> (out_item_o.trail_value == '0))
    else $error("trail on non-done result");

endmodule

bind pheromone_table_update_core ptu_checker u_ptu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
